>>> src/rcfp_pkg.sv
// shared types, constants and channel normalization helpers for the frame parser
package rcfp_pkg;

   // frame framing and flag bits
   localparam logic [7:0] SYNC_BYTE     = 8'h87;
   localparam int         FLAG_AUX_BIT  = 0;
   localparam int         FLAG_EXT_BIT  = 3;
   localparam int         FLAG_INIT_BIT = 4;

   // reverse mask bit positions
   localparam int REV_STEER    = 0;
   localparam int REV_THROTTLE = 1;
   localparam int REV_AUX      = 2;
   localparam int REV_AUX2     = 3;
   localparam int REV_AUX3     = 4;

   // aux value of a plain frame
   localparam logic signed [8:0] AUX_HIGH = 9'sd100;
   localparam logic signed [8:0] AUX_LOW  = -9'sd100;

   // frame queue depth and result bus width
   localparam int QUEUE_DEPTH = 2;
   localparam int RSP_DATA_W  = 88;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PARSER_ENABLED = 2'd0,
      CSR_MULTI_AUX      = 2'd1,
      CSR_REVERSE_MASK   = 2'd2
   } csr_index_type;

   // frame phases
   typedef enum logic [2:0] {
      PH_WAIT     = 3'd0,
      PH_STEER    = 3'd1,
      PH_THROTTLE = 3'd2,
      PH_FLAG     = 3'd3,
      PH_AUX      = 3'd4,
      PH_AUX2     = 3'd5,
      PH_AUX3     = 3'd6
   } phase_type;

   // one completed frame as it travels from front to back
   typedef struct packed {
      logic [7:0] steer;
      logic [7:0] throttle;
      logic [7:0] flag;
      logic [7:0] aux;
      logic [7:0] aux2;
      logic [7:0] aux3;
   } frame_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // configuration register set
   typedef struct packed {
      logic       parser_enabled;
      logic       multi_aux_enabled;
      logic [4:0] reverse_mask;
   } csr_type;

   // apply a reverse bit to a signed channel value
   function automatic logic signed [8:0] norm_value(input logic signed [8:0] v,
                                                    input logic rev);
      return rev ? -v : v;
   endfunction

   // read a byte as two's complement, then apply the reverse bit
   function automatic logic signed [8:0] norm_byte(input logic [7:0] b, input logic rev);
      logic signed [8:0] v;
      v = $signed({b[7], b});
      return norm_value(v, rev);
   endfunction

   // absolute value, 0..128 fits in eight bits
   function automatic logic [7:0] magnitude(input logic signed [8:0] v);
      logic [8:0] a;
      a = v[8] ? 9'(-v) : 9'(v);
      return a[7:0];
   endfunction

endpackage

>>> src/rc_channel_frame_parser_core.sv
// top level of the radio-control channel frame parser
//
// Bytes from a serial receiver enter on the req_ stream, one per request.
// A sync byte 0x87 starts a frame: steering, throttle and a flag byte,
// followed by three aux bytes when flag bit 3 is set. Each completed frame
// gives one request on the rsp_ stream with all five channels normalized
// (value and magnitude) and the initializing flag.
// Throughput: one byte per cycle while the frame queue has room. The byte that
// closes a frame is written into the frame queue at its accepting edge, and
// its result reaches rsp_tvalid through the back end's result register.
// The frame queue holds QueueDepth frames; req_tready drops only when it is
// full, which takes a stalled receiver plus at least QueueDepth more frames.
// Reset empties the queue, returns to waiting for sync, clears the held
// aux2 and aux3 channels and loads the register defaults (parser on,
// multi-aux off, no channel reversed). csr_ writes take effect at once and
// are meant for an idle block.
module rc_channel_frame_parser_core #(
   parameter int QueueDepth = rcfp_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream: [7:0] rx_byte
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   // result stream: [8:0] steer_value, [16:9] steer_magnitude,
   // [25:17] throttle_value, [33:26] throttle_magnitude, [42:34] aux_value,
   // [50:43] aux_magnitude, [59:51] aux2_value, [67:60] aux2_magnitude,
   // [76:68] aux3_value, [84:77] aux3_magnitude, [85] initializing
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [4:0]                      csr_wdata
);
   import rcfp_pkg::*;

   csr_type          csr_ff;
   queue_status_type q_status;
   frame_type        push_frame;
   frame_type        head_frame;
   logic             push;
   logic             pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.parser_enabled    <= 1'b1;
         csr_ff.multi_aux_enabled <= 1'b0;
         csr_ff.reverse_mask      <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PARSER_ENABLED: csr_ff.parser_enabled    <= csr_wdata[0];
            CSR_MULTI_AUX:      csr_ff.multi_aux_enabled <= csr_wdata[0];
            CSR_REVERSE_MASK:   csr_ff.reverse_mask      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // byte intake and frame assembly
   rcfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .parser_enabled (csr_ff.parser_enabled),
      .q_status       (q_status),
      .push           (push),
      .frame          (push_frame)
   );

   // frame queue
   rcfp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .status     (q_status)
   );

   // normalization and result register
   rcfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_valid    (!q_status.empty),
      .head_frame (head_frame),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a completed frame never lands in a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("frame pushed into full queue");

   // the back end never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("frame popped from empty queue");

   // a sync byte only restarts, it never closes a frame
   a_sync_no_frame: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata == SYNC_BYTE) |-> !push)
      else $error("sync byte completed a frame");

   // a disabled parser produces no frames
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      !csr_ff.parser_enabled |-> !push)
      else $error("frame completed while parser disabled");

endmodule

>>> src/rcfp_front.sv
// front end: byte intake, frame phase tracking and frame assembly
module rcfp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      parser_enabled,
   input  rcfp_pkg::queue_status_type q_status,
   output logic                      push,
   output rcfp_pkg::frame_type       frame
);
   import rcfp_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] steer_ff;
   logic [7:0] throttle_ff;
   logic [7:0] flag_ff;
   logic [7:0] aux_ff;
   logic [7:0] aux2_ff;
   logic       accept;
   logic       is_sync;
   logic       take;
   logic       cap_steer;
   logic       cap_throttle;
   logic       cap_flag;
   logic       cap_aux;
   logic       cap_aux2;

   // a request is taken whenever the queue has room
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_sync    = (req_tdata == SYNC_BYTE);
   assign take       = accept && parser_enabled && !is_sync;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && parser_enabled) begin
         if (is_sync) begin
            phase_in = PH_STEER;
         end else begin
            unique case (phase_ff)
               PH_WAIT:     phase_in = PH_WAIT;
               PH_STEER:    phase_in = PH_THROTTLE;
               PH_THROTTLE: phase_in = PH_FLAG;
               PH_FLAG:     phase_in = req_tdata[FLAG_EXT_BIT] ? PH_AUX : PH_WAIT;
               PH_AUX:      phase_in = PH_AUX2;
               PH_AUX2:     phase_in = PH_AUX3;
               PH_AUX3:     phase_in = PH_WAIT;
               default:     phase_in = PH_WAIT;
            endcase
         end
      end
   end

   // byte capture enables and frame completion
   always_comb begin
      cap_steer    = 1'b0;
      cap_throttle = 1'b0;
      cap_flag     = 1'b0;
      cap_aux      = 1'b0;
      cap_aux2     = 1'b0;
      push         = 1'b0;
      unique case (phase_ff)
         PH_STEER:    cap_steer    = take;
         PH_THROTTLE: cap_throttle = take;
         PH_FLAG: begin
            cap_flag = take;
            push     = take && !req_tdata[FLAG_EXT_BIT];
         end
         PH_AUX:      cap_aux      = take;
         PH_AUX2:     cap_aux2     = take;
         PH_AUX3:     push         = take;
         default: begin
         end
      endcase
   end

   // completed frame; the closing byte comes straight from the request
   always_comb begin
      frame.steer    = steer_ff;
      frame.throttle = throttle_ff;
      frame.flag     = (phase_ff == PH_FLAG) ? req_tdata : flag_ff;
      frame.aux      = aux_ff;
      frame.aux2     = aux2_ff;
      frame.aux3     = req_tdata;
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // frame byte registers
   always_ff @(posedge clock) begin
      if (cap_steer)    steer_ff    <= req_tdata;
      if (cap_throttle) throttle_ff <= req_tdata;
      if (cap_flag)     flag_ff     <= req_tdata;
      if (cap_aux)      aux_ff      <= req_tdata;
      if (cap_aux2)     aux2_ff     <= req_tdata;
   end

endmodule

>>> src/rcfp_queue.sv
// short frame queue between the front end and the back end
module rcfp_queue #(
   parameter int Depth = rcfp_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rcfp_pkg::frame_type        push_frame,
   input  logic                       pop,
   output rcfp_pkg::frame_type        head_frame,
   output rcfp_pkg::queue_status_type status
);
   import rcfp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   frame_type       entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_in;

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign head_frame   = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_frame;
   end

endmodule

>>> src/rcfp_back.sv
// back end: channel normalization, held aux channels and the result register
module rcfp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rcfp_pkg::csr_type                   csr,
   input  logic                                q_valid,
   input  rcfp_pkg::frame_type                 head_frame,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcfp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import rcfp_pkg::*;

   logic signed [8:0]     held_aux2_ff;
   logic signed [8:0]     held_aux3_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  ext;
   logic signed [8:0]     steer_v;
   logic signed [8:0]     throttle_v;
   logic signed [8:0]     aux_v;
   logic signed [8:0]     aux2_v;
   logic signed [8:0]     aux3_v;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // take the head frame when the result register is free or being emptied
   assign pop        = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // channel values
   always_comb begin
      ext        = csr.multi_aux_enabled && head_frame.flag[FLAG_EXT_BIT];
      steer_v    = norm_byte(head_frame.steer, csr.reverse_mask[REV_STEER]);
      throttle_v = norm_byte(head_frame.throttle, csr.reverse_mask[REV_THROTTLE]);
      if (ext) begin
         aux_v  = norm_byte(head_frame.aux, csr.reverse_mask[REV_AUX]);
         aux2_v = norm_byte(head_frame.aux2, csr.reverse_mask[REV_AUX2]);
         aux3_v = norm_byte(head_frame.aux3, csr.reverse_mask[REV_AUX3]);
      end else begin
         aux_v  = norm_value(head_frame.flag[FLAG_AUX_BIT] ? AUX_HIGH : AUX_LOW,
                             csr.reverse_mask[REV_AUX]);
         aux2_v = held_aux2_ff;
         aux3_v = held_aux3_ff;
      end
   end

   // result packing, highest field first
   always_comb begin
      rsp_data_in = {
         2'b00,
         head_frame.flag[FLAG_INIT_BIT],
         magnitude(aux3_v), aux3_v,
         magnitude(aux2_v), aux2_v,
         magnitude(aux_v), aux_v,
         magnitude(throttle_v), throttle_v,
         magnitude(steer_v), steer_v
      };
   end

   // held aux channels and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         held_aux2_ff <= '0;
         held_aux3_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop && ext) begin
            held_aux2_ff <= aux2_v;
            held_aux3_ff <= aux3_v;
         end
         if (pop) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> dv/rcfp_frame_checker.sv
// frame parser checker: tracks parser state from the streams and scores every result request
module rcfp_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [4:0]                      csr_wdata,
   output int                              frames_outstanding,
   output int                              fail_count
);
   import rcfp_pkg::*;

   // one result request, laid out as on rsp_tdata (top field first)
   typedef struct packed {
      logic              initializing;
      logic [7:0]        aux3_magnitude;
      logic signed [8:0] aux3_value;
      logic [7:0]        aux2_magnitude;
      logic signed [8:0] aux2_value;
      logic [7:0]        aux_magnitude;
      logic signed [8:0] aux_value;
      logic [7:0]        throttle_magnitude;
      logic signed [8:0] throttle_value;
      logic [7:0]        steer_magnitude;
      logic signed [8:0] steer_value;
   } channel_frame_type;

   csr_type           settings;
   phase_type         phase;
   logic [7:0]        steer_byte;
   logic [7:0]        throttle_byte;
   logic [7:0]        flag_byte;
   logic [7:0]        aux_byte;
   logic [7:0]        aux2_byte;
   logic signed [8:0] held_aux2;
   logic signed [8:0] held_aux3;
   channel_frame_type pending_frames[$];

   initial fail_count = 0;

   // byte as two's complement, flipped when the channel is reversed
   function automatic logic signed [8:0] signed_channel(input logic [7:0] b, input logic rev);
      logic signed [8:0] v;
      v = $signed({b[7], b});
      return rev ? 9'sd0 - v : v;
   endfunction

   function automatic logic [7:0] channel_abs(input logic signed [8:0] v);
      logic signed [8:0] a;
      a = (v < 0) ? 9'sd0 - v : v;
      return a[7:0];
   endfunction

   // channels of a completed frame; extended frames with multi-aux refresh aux2/aux3
   function automatic channel_frame_type complete_frame(input logic [7:0] last_byte);
      channel_frame_type r;
      logic signed [8:0] aux;
      if (settings.multi_aux_enabled && flag_byte[FLAG_EXT_BIT]) begin
         aux       = signed_channel(aux_byte, settings.reverse_mask[REV_AUX]);
         held_aux2 = signed_channel(aux2_byte, settings.reverse_mask[REV_AUX2]);
         held_aux3 = signed_channel(last_byte, settings.reverse_mask[REV_AUX3]);
      end else begin
         aux = flag_byte[FLAG_AUX_BIT] ? AUX_HIGH : AUX_LOW;
         if (settings.reverse_mask[REV_AUX]) aux = 9'sd0 - aux;
      end
      r.steer_value        = signed_channel(steer_byte, settings.reverse_mask[REV_STEER]);
      r.steer_magnitude    = channel_abs(r.steer_value);
      r.throttle_value     = signed_channel(throttle_byte, settings.reverse_mask[REV_THROTTLE]);
      r.throttle_magnitude = channel_abs(r.throttle_value);
      r.aux_value          = aux;
      r.aux_magnitude      = channel_abs(aux);
      r.aux2_value         = held_aux2;
      r.aux2_magnitude     = channel_abs(held_aux2);
      r.aux3_value         = held_aux3;
      r.aux3_magnitude     = channel_abs(held_aux3);
      r.initializing       = flag_byte[FLAG_INIT_BIT];
      return r;
   endfunction

   // advance the frame phase on one received byte
   task automatic take_byte(input logic [7:0] b);
      if (!settings.parser_enabled) return;
      if (b == SYNC_BYTE) begin
         phase = PH_STEER;
         return;
      end
      case (phase)
         PH_STEER: begin
            steer_byte = b;
            phase = PH_THROTTLE;
         end
         PH_THROTTLE: begin
            throttle_byte = b;
            phase = PH_FLAG;
         end
         PH_FLAG: begin
            flag_byte = b;
            if (b[FLAG_EXT_BIT]) begin
               phase = PH_AUX;
            end else begin
               phase = PH_WAIT;
               pending_frames.push_back(complete_frame(8'h00));
            end
         end
         PH_AUX: begin
            aux_byte = b;
            phase = PH_AUX2;
         end
         PH_AUX2: begin
            aux2_byte = b;
            phase = PH_AUX3;
         end
         PH_AUX3: begin
            phase = PH_WAIT;
            pending_frames.push_back(complete_frame(b));
         end
         default: phase = PH_WAIT;
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_frame(input channel_frame_type want, input channel_frame_type got);
      check_field("steer_value", $signed(want.steer_value), $signed(got.steer_value));
      check_field("steer_magnitude", want.steer_magnitude, got.steer_magnitude);
      check_field("throttle_value", $signed(want.throttle_value), $signed(got.throttle_value));
      check_field("throttle_magnitude", want.throttle_magnitude, got.throttle_magnitude);
      check_field("aux_value", $signed(want.aux_value), $signed(got.aux_value));
      check_field("aux_magnitude", want.aux_magnitude, got.aux_magnitude);
      check_field("aux2_value", $signed(want.aux2_value), $signed(got.aux2_value));
      check_field("aux2_magnitude", want.aux2_magnitude, got.aux2_magnitude);
      check_field("aux3_value", $signed(want.aux3_value), $signed(got.aux3_value));
      check_field("aux3_magnitude", want.aux3_magnitude, got.aux3_magnitude);
      check_field("initializing", want.initializing, got.initializing);
   endtask

   // results are scored before new requests so no result can match its own byte
   always @(posedge clock) begin
      channel_frame_type got;
      if (reset) begin
         settings  = '{1'b1, 1'b0, 5'd0};
         phase     = PH_WAIT;
         held_aux2 = '0;
         held_aux3 = '0;
         pending_frames.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(channel_frame_type)-1:0];
            if (pending_frames.size() == 0) begin
               $error("result request with no frame pending");
               fail_count++;
            end else begin
               check_frame(pending_frames.pop_front(), got);
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_PARSER_ENABLED: settings.parser_enabled    = csr_wdata[0];
               CSR_MULTI_AUX:      settings.multi_aux_enabled = csr_wdata[0];
               CSR_REVERSE_MASK:   settings.reverse_mask      = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_byte(req_tdata);
      end
      frames_outstanding = pending_frames.size();
   end

endmodule

>>> dv/rc_channel_frame_parser_core_test.sv
// frame parser testbench top: byte stimulus, settings phases, stalls and verdict
module rc_channel_frame_parser_core_test;
   import rcfp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [1:0]            csr_addr;
   logic [4:0]            csr_wdata;

   int   send_idle_pct;
   int   recv_idle_pct;
   int   frames_outstanding;
   int   fail_count;
   int   cycle_count;
   int   counted_bytes;
   logic parser_on;
   logic [7:0] burst[$];

   rc_channel_frame_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   rcfp_frame_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .frames_outstanding (frames_outstanding),
      .fail_count         (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // data byte biased toward the two's complement extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [4:0] pick_mask();
      case ($urandom_range(3))
         0: return 5'd0;
         1: return 5'h1F;
         default: return 5'($urandom_range(31));
      endcase
   endfunction

   // one request on the byte stream, with random sender gaps; valid stays up afterwards
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (parser_on) counted_bytes++;
   endtask

   // drain all pending frames, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (frames_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [4:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic en, input logic multi, input logic [4:0] mask);
      wait_idle();
      write_csr(CSR_PARSER_ENABLED, {4'd0, en});
      write_csr(CSR_MULTI_AUX, {4'd0, multi});
      write_csr(CSR_REVERSE_MASK, mask);
      csr_we    <= 1'b0;
      parser_on = en;
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_byte(burst[i]);
   endtask

   // well-formed frame with random content
   task automatic send_frame(input logic extended);
      logic [7:0] flag;
      flag = 8'($urandom_range(255));
      flag[FLAG_EXT_BIT] = extended;
      send_byte(SYNC_BYTE);
      send_byte(pick_byte());
      send_byte(pick_byte());
      send_byte(flag);
      if (extended) repeat (3) send_byte(pick_byte());
   endtask

   // stray bytes or a frame cut short
   task automatic send_noise();
      if ($urandom_range(1) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(SYNC_BYTE);
         repeat ($urandom_range(0, 5)) send_byte(pick_byte());
      end
   endtask

   task automatic run_segment(input int n_bytes);
      int target;
      target = counted_bytes + n_bytes;
      while (counted_bytes < target) begin
         if ($urandom_range(9) < 8) send_frame(1'($urandom_range(1)));
         else send_noise();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_addr      = 2'd0;
      csr_wdata     = 5'd0;
      parser_on     = 1'b1;
      counted_bytes = 0;
      send_idle_pct = 20;
      recv_idle_pct = 55;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: bytes while waiting, plain frame, sync mid-frame,
      // extended frame with multi-aux off
      burst = '{8'h00, 8'hFF, SYNC_BYTE, 8'h7F, 8'h80, 8'h11,
                SYNC_BYTE, 8'h00, SYNC_BYTE, 8'h81, 8'hFF, 8'h08, 8'h01, 8'h02, 8'h03};
      send_burst();
      // extended frame with multi-aux on and every channel reversed
      apply_settings(1'b1, 1'b1, 5'h1F);
      burst = '{SYNC_BYTE, 8'h80, 8'h7F, 8'h19, 8'h80, 8'h7F, 8'hFF};
      send_burst();
      // parser off: even the sync byte is dropped
      apply_settings(1'b0, 1'b1, 5'd0);
      burst = '{SYNC_BYTE, 8'h01, 8'h02, 8'h00};
      send_burst();

      // random frames over three stall profiles, fresh settings per segment
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < 4; s++) begin
            if ($urandom_range(3) == 0) begin
               apply_settings(1'b0, 1'($urandom_range(1)), pick_mask());
               repeat (12) send_byte(pick_byte());
            end
            apply_settings(1'b1, 1'($urandom_range(1)), pick_mask());
            run_segment(100);
         end
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
